// ===== sv/prsd_pkg.sv =====
// shared types and constants of the packed relocation stream decoder
package prsd_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned OffsetW    = 32;
  localparam int unsigned LengthW    = 24;
  localparam int unsigned CountW     = LengthW + 1;
  localparam int unsigned PhaseW     = 2;
  localparam int unsigned ResultDepth = 3;
  localparam int unsigned FillW      = $clog2(ResultDepth + 1);

  // phase codes
  localparam logic [PhaseW-1:0] PhaseCode   = 2'd0;
  localparam logic [PhaseW-1:0] PhaseMarker = 2'd1;

  // fixup kinds
  localparam logic KindWord = 1'b0;
  localparam logic KindBase = 1'b1;

  // delta masks
  localparam logic [OffsetW-1:0] LoadKeepMask = 32'hFFFF_8000;
  localparam logic [OffsetW-1:0] DoneKeepMask = 32'hFFFF_FFF0;

  typedef struct packed {
    logic [ByteW-1:0] table_byte;
    logic             start_of_table;
  } in_item_t;

  typedef struct packed {
    logic [OffsetW-1:0] fixup_offset;
    logic               fixup_kind;
    logic               last_of_run;
  } out_item_t;

  typedef struct packed {
    logic [OffsetW-1:0] delta_accum;
    logic [OffsetW-1:0] running_offset;
    logic [CountW-1:0]  bytes_consumed;
    logic [PhaseW-1:0]  phase;
  } dec_state_t;

  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } result_push_t;

endpackage

// ===== sv/prsd_decode.sv =====
// combinational decode of one table byte against the held decoder state
module prsd_decode (
  input  prsd_pkg::in_item_t                  item_i,
  input  logic [prsd_pkg::LengthW-1:0]        table_length_i,
  input  prsd_pkg::dec_state_t                state_i,
  output prsd_pkg::dec_state_t                state_o,
  output prsd_pkg::result_push_t              push_o
);
  import prsd_pkg::*;

  dec_state_t         st;
  logic [ByteW-1:0]   rot;
  logic [CountW-1:0]  pos;
  logic               in_range;
  logic               is_last;
  logic               code_emits;
  logic [OffsetW-1:0] load_delta;
  logic [OffsetW-1:0] done_sum;
  logic [OffsetW-1:0] done_delta;
  logic [OffsetW-1:0] new_off;

  always_comb begin
    st = state_i;
    if (item_i.start_of_table) begin
      st = '0;
      st.phase = PhaseCode;
    end
  end

  assign rot        = {item_i.table_byte[2:0], item_i.table_byte[7:3]};
  assign pos        = st.bytes_consumed + CountW'(1);
  assign in_range   = pos <= {1'b0, table_length_i};
  assign is_last    = pos == {1'b0, table_length_i};
  assign load_delta = (st.delta_accum & LoadKeepMask) | {17'd0, rot, 7'd0};
  assign done_sum   = (st.delta_accum & DoneKeepMask) + {24'd0, rot};
  assign done_delta = {1'b0, done_sum[OffsetW-1:1]};
  assign new_off    = st.running_offset + done_delta;
  assign code_emits = !rot[0] && is_last;

  always_comb begin
    logic do_code;
    do_code = 1'b0;
    state_o = st;
    push_o  = '0;
    if (in_range) begin
      state_o.bytes_consumed = pos;
      unique case (st.phase)
        PhaseMarker: begin
          if (item_i.table_byte == '0) begin
            state_o.phase = PhaseCode;
            push_o.count  = 2'd1;
            push_o.first  = '{fixup_offset: st.running_offset, fixup_kind: KindWord,
                              last_of_run: 1'b1};
          end else begin
            // nonzero marker: base result, then the same byte as a code byte
            do_code = 1'b1;
            push_o.first = '{fixup_offset: st.running_offset, fixup_kind: KindBase,
                             last_of_run: !code_emits};
            push_o.second = '{fixup_offset: new_off, fixup_kind: KindBase,
                              last_of_run: 1'b1};
            push_o.count = code_emits ? 2'd2 : 2'd1;
          end
        end
        default: begin
          do_code = 1'b1;
          push_o.first = '{fixup_offset: new_off, fixup_kind: KindBase, last_of_run: 1'b1};
          push_o.count = code_emits ? 2'd1 : 2'd0;
        end
      endcase
      if (do_code) begin
        if (rot[0]) begin
          state_o.delta_accum = load_delta;
          state_o.phase       = PhaseCode;
        end else begin
          state_o.delta_accum    = done_delta;
          state_o.running_offset = new_off;
          state_o.phase          = is_last ? PhaseCode : PhaseMarker;
        end
      end
    end
  end

endmodule

// ===== sv/prsd_result_fifo.sv =====
// shifting result queue that takes up to two results per cycle
module prsd_result_fifo (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  prsd_pkg::result_push_t push_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output prsd_pkg::out_item_t    out_item_o
);
  import prsd_pkg::*;

  out_item_t        slot_q [ResultDepth];
  out_item_t        slot_d [ResultDepth];
  logic [FillW-1:0] fill_q, fill_d;
  logic             pop;
  logic [FillW-1:0] base;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = fill_q != '0;
  assign out_item_o  = slot_q[0];
  assign room_o      = fill_q <= FillW'(1);
  assign base        = fill_q - FillW'(pop);
  assign fill_d      = base + FillW'(push_i.count);

  always_comb begin
    for (int i = 0; i < ResultDepth; i++) begin
      if (pop && (i < ResultDepth - 1)) begin
        slot_d[i] = slot_q[i+1];
      end else begin
        slot_d[i] = slot_q[i];
      end
      if ((push_i.count != 2'd0) && (FillW'(i) == base)) begin
        slot_d[i] = push_i.first;
      end
      if ((push_i.count == 2'd2) && (FillW'(i) == base + FillW'(1))) begin
        slot_d[i] = push_i.second;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < ResultDepth; i++) begin
      slot_q[i] <= slot_d[i];
    end
  end

endmodule

// ===== sv/packed_relocation_stream_decoder.sv =====
// top level of the packed relocation stream decoder
//
// takes one table byte per transaction and turns the packed relocation table
// into absolute fixup offsets. a byte is accepted into an input register,
// decoded from there against the running state (rotate, mask, delta add,
// offset add, length compare) once the queue has room, and its results go
// into a three-entry result queue. one byte per cycle is sustained while the
// consumer keeps up; a byte that yields two results stalls the input, since
// the queue then holds two entries and the input register waits until one
// drains. bytes past table_length give no result. the user must write
// table_length through cfg_we_i only while no transaction is in flight; the
// block itself does not enforce this.
module packed_relocation_stream_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [prsd_pkg::LengthW-1:0] cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  prsd_pkg::in_item_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output prsd_pkg::out_item_t          out_item_o
);
  import prsd_pkg::*;

  // configuration
  logic [LengthW-1:0] table_length_q;

  // input register
  logic     in_valid_q;
  in_item_t in_item_q;

  // decoder state
  dec_state_t   state_q, state_d;
  result_push_t dec_push;
  result_push_t push;

  logic room;
  logic proc;
  logic in_accept;

  // decode the held byte when the queue has room for two results
  assign proc       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || room;
  assign in_accept  = in_valid_i && in_ready_o;

  prsd_decode u_decode (
    .item_i         (in_item_q),
    .table_length_i (table_length_q),
    .state_i        (state_q),
    .state_o        (state_d),
    .push_o         (dec_push)
  );

  // only push when the byte is actually consumed
  always_comb begin
    push = dec_push;
    if (!proc) begin
      push.count = 2'd0;
    end
  end

  prsd_result_fifo u_result_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_length_q <= '0;
      in_valid_q     <= 1'b0;
      state_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        table_length_q <= cfg_wdata_i;
      end
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (proc) begin
        state_q <= state_d;
      end
    end
  end

  // input payload register
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_item_q <= in_item_i;
    end
  end

`ifndef SYNTHESIS
  // a held byte waiting on the queue keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !proc |=> in_valid_q && $stable(in_item_q))
    else $error("held input byte lost or changed while stalled");

  // a consumed byte with results makes the output valid next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && (push.count != 2'd0) |=> out_valid_o)
    else $error("results pushed but output not valid");

  // with two results only the second one closes the run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.count == 2'd2 |-> !push.first.last_of_run && push.second.last_of_run)
    else $error("last_of_run misplaced on a two-result byte");

  // a byte ignored past the table leaves the running offset unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && !in_item_q.start_of_table && (push.count == 2'd0)
      && (state_d.bytes_consumed == state_q.bytes_consumed)
      |=> $stable(state_q.running_offset))
    else $error("offset moved on an ignored byte");
`endif

endmodule
